FILE: hdl/bfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Brainfuck machine package
// Shared widths, character codes, status codes and controller states.
// ----------------------------------------------------------------------------
package bfm_pkg;

   localparam int unsigned TAPE_DEPTH_DEF = 1024 * 32;
   localparam int unsigned PROG_DEPTH_DEF = 4096;

   localparam int unsigned LEN_W  = 13;
   localparam int unsigned ADDR_W = 12;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned STAT_W = 2;

   typedef logic [BYTE_W-1:0] byte_type;

   localparam byte_type CH_OPEN  = 8'h5B;
   localparam byte_type CH_CLOSE = 8'h5D;
   localparam byte_type CH_RIGHT = 8'h3E;
   localparam byte_type CH_LEFT  = 8'h3C;
   localparam byte_type CH_INC   = 8'h2B;
   localparam byte_type CH_DEC   = 8'h2D;
   localparam byte_type CH_OUT   = 8'h2E;
   localparam byte_type CH_IN    = 8'h2C;

   typedef enum logic [STAT_W-1:0] {
      ST_RUN         = 2'd0,
      ST_END         = 2'd1,
      ST_UNBALANCED  = 2'd2,
      ST_CLOSE_FIRST = 2'd3
   } status_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_SCAN
   } state_type;

endpackage : bfm_pkg
`default_nettype wire

FILE: hdl/bfm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Brainfuck machine channels
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bfm_req_if;
   import bfm_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [ADDR_W-1:0] prog_addr;
   logic [BYTE_W-1:0] prog_byte;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, operation, prog_addr, prog_byte, in_byte,
                   input ready);
   modport sink   (input valid, operation, prog_addr, prog_byte, in_byte,
                   output ready);
endinterface : bfm_req_if

interface bfm_rsp_if;
   import bfm_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              out_valid;
   logic              input_taken;
   logic [STAT_W-1:0] run_status;

   modport source (output valid, out_byte, out_valid, input_taken, run_status,
                   input ready);
   modport sink   (input valid, out_byte, out_valid, input_taken, run_status,
                   output ready);
endinterface : bfm_rsp_if

interface bfm_csr_if;
   import bfm_pkg::*;

   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] program_length;

   modport source (output valid, program_length, input ready);
   modport sink   (input valid, program_length, output ready);
endinterface : bfm_csr_if
`default_nettype wire

FILE: hdl/bfm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bfm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : bfm_ram
`default_nettype wire

FILE: hdl/bfm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Brainfuck machine controller
// Holds the program store and tape memories and sequences loads, instruction
// execution, bracket scans and the tape clear after reset.
// ----------------------------------------------------------------------------
module bfm_ctrl #(
   parameter int unsigned TAPE_DEPTH = bfm_pkg::TAPE_DEPTH_DEF,
   parameter int unsigned PROG_DEPTH = bfm_pkg::PROG_DEPTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [bfm_pkg::LEN_W-1:0] eff_length,
   bfm_req_if.sink                      req_bus,
   bfm_rsp_if.source                    rsp_bus
);
   import bfm_pkg::*;

   localparam int unsigned TAW = $clog2(TAPE_DEPTH);
   localparam int unsigned PAW = $clog2(PROG_DEPTH);
   localparam int unsigned PCW = $clog2(PROG_DEPTH + 1);
   localparam int unsigned CW  = (PCW > LEN_W) ? PCW : LEN_W;

   state_type         state_ff, state_in;
   logic [TAW-1:0]    clr_ff, clr_in;
   logic [PCW-1:0]    pc_ff, pc_in;
   logic [TAW-1:0]    dp_ff, dp_in;
   status_type        halt_ff, halt_in;
   logic [PCW-1:0]    scan_ff, scan_in;
   logic [PCW-1:0]    depth_ff, depth_in;
   logic              fwd_ff, fwd_in;
   byte_type          in_byte_ff, in_byte_in;

   logic              rsp_valid_ff, rsp_valid_in;
   byte_type          rsp_byte_ff, rsp_byte_in;
   logic              rsp_oval_ff, rsp_oval_in;
   logic              rsp_itk_ff, rsp_itk_in;
   status_type        rsp_stat_ff, rsp_stat_in;

   logic              prog_wr_en, prog_rd_en;
   logic [PAW-1:0]    prog_rd_addr;
   byte_type          prog_rd_data;
   logic              tape_wr_en, tape_rd_en;
   logic [TAW-1:0]    tape_wr_addr;
   byte_type          tape_wr_data;
   byte_type          tape_rd_data;

   logic              req_ready;
   logic              slot_free;
   logic              done;
   byte_type          done_byte;
   logic              done_oval;
   logic              done_itk;
   logic              fin;
   logic [PCW-1:0]    fin_pc;
   logic [PCW-1:0]    pc_next;
   logic [PCW-1:0]    scan_next;
   logic [CW-1:0]     len_ext;

   bfm_ram #(.WIDTH(BYTE_W), .DEPTH(PROG_DEPTH)) u_prog_ram (
      .clock   (clock),
      .wr_en   (prog_wr_en),
      .wr_addr (PAW'(req_bus.prog_addr)),
      .wr_data (req_bus.prog_byte),
      .rd_en   (prog_rd_en),
      .rd_addr (prog_rd_addr),
      .rd_data (prog_rd_data)
   );

   bfm_ram #(.WIDTH(BYTE_W), .DEPTH(TAPE_DEPTH)) u_tape_ram (
      .clock   (clock),
      .wr_en   (tape_wr_en),
      .wr_addr (tape_wr_addr),
      .wr_data (tape_wr_data),
      .rd_en   (tape_rd_en),
      .rd_addr (dp_ff),
      .rd_data (tape_rd_data)
   );

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign len_ext   = CW'(eff_length);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         dp_ff        <= '0;
         halt_ff      <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         dp_ff        <= dp_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff     <= scan_in;
      depth_ff    <= depth_in;
      fwd_ff      <= fwd_in;
      in_byte_ff  <= in_byte_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_oval_ff <= rsp_oval_in;
      rsp_itk_ff  <= rsp_itk_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pc_in        = pc_ff;
      dp_in        = dp_ff;
      halt_in      = halt_ff;
      scan_in      = scan_ff;
      depth_in     = depth_ff;
      fwd_in       = fwd_ff;
      in_byte_in   = in_byte_ff;
      prog_wr_en   = 1'b0;
      prog_rd_en   = 1'b0;
      prog_rd_addr = pc_ff[PAW-1:0];
      tape_wr_en   = 1'b0;
      tape_rd_en   = 1'b0;
      tape_wr_addr = dp_ff;
      tape_wr_data = '0;
      req_ready    = 1'b0;
      done         = 1'b0;
      done_byte    = '0;
      done_oval    = 1'b0;
      done_itk     = 1'b0;
      fin          = 1'b0;
      fin_pc       = pc_ff;
      pc_next      = pc_ff + 1'b1;
      scan_next    = fwd_ff ? scan_ff + 1'b1 : scan_ff - 1'b1;

      unique case (state_ff)
         S_CLEAR: begin
            tape_wr_en   = 1'b1;
            tape_wr_addr = clr_ff;
            if (clr_ff == TAW'(TAPE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            req_ready = slot_free;
            if (req_bus.valid && slot_free) begin
               if (req_bus.operation == OP_LOAD) begin
                  prog_wr_en = (32'(req_bus.prog_addr) < PROG_DEPTH);
                  done       = 1'b1;
               end else if (halt_ff != ST_RUN) begin
                  done = 1'b1;
               end else if (CW'(pc_ff) >= len_ext) begin
                  halt_in = ST_END;
                  done    = 1'b1;
               end else begin
                  prog_rd_en = 1'b1;
                  tape_rd_en = 1'b1;
                  in_byte_in = req_bus.in_byte;
                  state_in   = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            unique case (prog_rd_data)
               CH_RIGHT: begin
                  dp_in = (dp_ff == TAW'(TAPE_DEPTH - 1)) ? '0 : dp_ff + 1'b1;
                  fin   = 1'b1;
               end
               CH_LEFT: begin
                  dp_in = (dp_ff == '0) ? TAW'(TAPE_DEPTH - 1) : dp_ff - 1'b1;
                  fin   = 1'b1;
               end
               CH_INC: begin
                  tape_wr_en   = 1'b1;
                  tape_wr_data = tape_rd_data + 1'b1;
                  fin          = 1'b1;
               end
               CH_DEC: begin
                  tape_wr_en   = 1'b1;
                  tape_wr_data = tape_rd_data - 1'b1;
                  fin          = 1'b1;
               end
               CH_OUT: begin
                  done_byte = tape_rd_data;
                  done_oval = 1'b1;
                  fin       = 1'b1;
               end
               CH_IN: begin
                  tape_wr_en   = 1'b1;
                  tape_wr_data = in_byte_ff;
                  done_itk     = 1'b1;
                  fin          = 1'b1;
               end
               CH_OPEN: begin
                  if (tape_rd_data != '0) begin
                     fin = 1'b1;
                  end else if (CW'(pc_next) >= len_ext) begin
                     halt_in  = ST_UNBALANCED;
                     done     = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     prog_rd_en   = 1'b1;
                     prog_rd_addr = pc_next[PAW-1:0];
                     scan_in      = pc_next;
                     depth_in     = '0;
                     fwd_in       = 1'b1;
                     state_in     = S_SCAN;
                  end
               end
               CH_CLOSE: begin
                  if (tape_rd_data == '0) begin
                     fin = 1'b1;
                  end else if (pc_ff == '0) begin
                     halt_in  = ST_CLOSE_FIRST;
                     done     = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     prog_rd_en   = 1'b1;
                     prog_rd_addr = PAW'(pc_ff - 1'b1);
                     scan_in      = pc_ff - 1'b1;
                     depth_in     = '0;
                     fwd_in       = 1'b0;
                     state_in     = S_SCAN;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         S_SCAN: begin
            if ((fwd_ff && prog_rd_data == CH_CLOSE && depth_ff == '0) ||
                (!fwd_ff && prog_rd_data == CH_OPEN && depth_ff == '0)) begin
               fin    = 1'b1;
               fin_pc = scan_ff;
            end else begin
               if (prog_rd_data == (fwd_ff ? CH_OPEN : CH_CLOSE)) begin
                  depth_in = depth_ff + 1'b1;
               end else if (prog_rd_data == (fwd_ff ? CH_CLOSE : CH_OPEN)) begin
                  depth_in = depth_ff - 1'b1;
               end
               if ((fwd_ff && CW'(scan_next) >= len_ext) ||
                   (!fwd_ff && scan_ff == '0)) begin
                  halt_in  = ST_UNBALANCED;
                  done     = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  prog_rd_en   = 1'b1;
                  prog_rd_addr = scan_next[PAW-1:0];
                  scan_in      = scan_next;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         pc_in = fin_pc + 1'b1;
         if (CW'(pc_in) >= len_ext) begin
            halt_in = ST_END;
         end
         done     = 1'b1;
         state_in = S_IDLE;
      end

      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_byte_in = done ? done_byte : rsp_byte_ff;
      rsp_oval_in = done ? done_oval : rsp_oval_ff;
      rsp_itk_in  = done ? done_itk : rsp_itk_ff;
      rsp_stat_in = done ? halt_in : rsp_stat_ff;
   end

   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_byte    = rsp_byte_ff;
   assign rsp_bus.out_valid   = rsp_oval_ff;
   assign rsp_bus.input_taken = rsp_itk_ff;
   assign rsp_bus.run_status  = rsp_stat_ff;

endmodule : bfm_ctrl
`default_nettype wire

FILE: hdl/brainfuck_machine_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Brainfuck machine
// Runs a Brainfuck program from a program store over a wrapping byte tape,
// one instruction for each step word.
// ----------------------------------------------------------------------------
// A request word either loads one program byte or executes one instruction;
// every request word yields exactly one response word on the response channel.
// The register channel sets the program length and is always ready.
// After reset the tape is cleared one cell a cycle, all TAPE_DEPTH cells,
// and no request word is taken until that pass is over.
// A load, or a step while halted or at the program end, has its response
// registered in the cycle after acceptance. An ordinary instruction reads
// the program byte and the tape cell in S_IDLE, then executes and writes
// the cell back in S_EXEC. A bracket jump adds a scan in S_SCAN, which
// reads the program store one byte a cycle.
// A request word is taken only while the response register is empty or is
// being emptied in the same cycle, so a stalled receiver holds the response
// word in place and holds off the next request.
// ----------------------------------------------------------------------------
module brainfuck_machine_step #(
   parameter int unsigned TAPE_DEPTH = bfm_pkg::TAPE_DEPTH_DEF,
   parameter int unsigned PROG_DEPTH = bfm_pkg::PROG_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   bfm_req_if.sink   req_bus,
   bfm_rsp_if.source rsp_bus,
   bfm_csr_if.sink   csr_bus
);
   import bfm_pkg::*;

   logic [LEN_W-1:0] length_ff, length_in;
   logic [LEN_W-1:0] eff_length;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
   end

   always_comb begin
      length_in = length_ff;
      if (csr_bus.valid) begin
         length_in = csr_bus.program_length;
      end
   end

   assign csr_bus.ready = 1'b1;
   assign eff_length    = (32'(length_ff) > PROG_DEPTH) ? LEN_W'(PROG_DEPTH) : length_ff;

   bfm_ctrl #(
      .TAPE_DEPTH (TAPE_DEPTH),
      .PROG_DEPTH (PROG_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .eff_length (eff_length),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus)
   );

endmodule : brainfuck_machine_step
`default_nettype wire

FILE: verif/brainfuck_machine_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brainfuck machine testbench
// Loads short generated programs word by word, grows the program length and
// single-steps the machine, predicting every response word from a private
// copy of the program store, tape, counters and halt code. Loops are built
// so that they always terminate, and the run ends with one of the halt
// conditions followed by steps and length writes on the halted machine.
// ----------------------------------------------------------------------------
module brainfuck_machine_step_tb;
   import bfm_pkg::*;

   localparam int unsigned ITEMS       = 1250;
   localparam int unsigned CALM_ITEMS  = 150;
   localparam int unsigned STALL_LIMIT = 200000;

   typedef logic [ADDR_W-1:0] addr_word;

   typedef struct packed {
      byte_type   out_byte;
      logic       out_valid;
      logic       input_taken;
      status_type run_status;
   } bf_response;

   class machine_tracker;
      byte_type    program_mem [PROG_DEPTH_DEF];
      byte_type    tape_mem [TAPE_DEPTH_DEF];
      int unsigned pc;
      int unsigned dp;
      int unsigned prog_len;
      status_type  halt;
      bf_response  due_results [$];
      int unsigned n_loads, n_steps, n_jumps, n_out, n_in, n_errors;

      function new();
         foreach (program_mem[i]) program_mem[i] = '0;
         foreach (tape_mem[i]) tape_mem[i] = '0;
         pc       = 0;
         dp       = 0;
         prog_len = 0;
         halt     = ST_RUN;
         n_loads  = 0;
         n_steps  = 0;
         n_jumps  = 0;
         n_out    = 0;
         n_in     = 0;
         n_errors = 0;
      endfunction

      function void complain(string msg);
         n_errors++;
         if (n_errors <= 10) begin
            $display("ERROR: %s", msg);
         end
      endfunction

      function void take_request(op_type op, addr_word addr, byte_type pb, byte_type ib);
         bf_response  r;
         int unsigned len, pos, p, depth;
         byte_type    cur;
         bit          found;
         r     = '0;
         found = 1'b0;
         depth = 0;
         len   = (prog_len > PROG_DEPTH_DEF) ? PROG_DEPTH_DEF : prog_len;
         if (op == OP_LOAD) begin
            program_mem[addr] = pb;
            n_loads++;
         end else begin
            n_steps++;
            if (halt == ST_RUN && pc >= len) begin
               halt = ST_END;
            end else if (halt == ST_RUN) begin
               pos = pc;
               cur = tape_mem[dp];
               case (program_mem[pc])
                  CH_RIGHT: dp = (dp + 1 >= TAPE_DEPTH_DEF) ? 0 : dp + 1;
                  CH_LEFT:  dp = (dp == 0) ? TAPE_DEPTH_DEF - 1 : dp - 1;
                  CH_INC:   tape_mem[dp] = cur + 8'd1;
                  CH_DEC:   tape_mem[dp] = cur - 8'd1;
                  CH_OUT: begin
                     r.out_byte  = cur;
                     r.out_valid = 1'b1;
                     n_out++;
                  end
                  CH_IN: begin
                     tape_mem[dp]  = ib;
                     r.input_taken = 1'b1;
                     n_in++;
                  end
                  CH_OPEN: begin
                     if (cur == 8'd0) begin
                        p = pos + 1;
                        while (!found && p < len) begin
                           if (program_mem[p] == CH_OPEN) begin
                              depth++;
                           end else if (program_mem[p] == CH_CLOSE) begin
                              if (depth == 0) found = 1'b1;
                              else depth--;
                           end
                           if (!found) p++;
                        end
                        if (found) begin
                           pos = p;
                           n_jumps++;
                        end else begin
                           halt = ST_UNBALANCED;
                        end
                     end
                  end
                  CH_CLOSE: begin
                     if (cur != 8'd0 && pos == 0) begin
                        halt = ST_CLOSE_FIRST;
                     end else if (cur != 8'd0) begin
                        p = pos;
                        while (!found && p > 0) begin
                           p--;
                           if (program_mem[p] == CH_CLOSE) begin
                              depth++;
                           end else if (program_mem[p] == CH_OPEN) begin
                              if (depth == 0) found = 1'b1;
                              else depth--;
                           end
                        end
                        if (found) begin
                           pos = p;
                           n_jumps++;
                        end else begin
                           halt = ST_UNBALANCED;
                        end
                     end
                  end
                  default: ;
               endcase
               if (halt == ST_RUN) begin
                  pc = pos + 1;
                  if (pc >= len) halt = ST_END;
               end
            end
         end
         r.run_status = halt;
         due_results.push_back(r);
      endfunction

      function void match_response(bf_response got);
         bf_response want;
         if (due_results.size() == 0) begin
            complain($sformatf("response word with none due: byte %02h valid %0b taken %0b status %0d",
                               got.out_byte, got.out_valid, got.input_taken, got.run_status));
            return;
         end
         want = due_results.pop_front();
         if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
             got.input_taken !== want.input_taken || got.run_status !== want.run_status) begin
            complain($sformatf({"expected byte %02h valid %0b taken %0b status %0d, ",
                                "got byte %02h valid %0b taken %0b status %0d"},
                               want.out_byte, want.out_valid, want.input_taken, want.run_status,
                               got.out_byte, got.out_valid, got.input_taken, got.run_status));
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   bfm_req_if req_bus ();
   bfm_rsp_if rsp_bus ();
   bfm_csr_if csr_bus ();

   brainfuck_machine_step i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   machine_tracker tracker;
   bit             calm         = 1'b0;
   bit             open_to_zero = 1'b0;
   int unsigned    prog_top     = 0;
   int unsigned    words_sent   = 0;
   int unsigned    length_writes = 0;
   int unsigned    stall_left   = 0;
   int unsigned    quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left    <= $urandom_range(0, 10);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      bf_response got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.out_byte    = rsp_bus.out_byte;
         got.out_valid   = rsp_bus.out_valid;
         got.input_taken = rsp_bus.input_taken;
         got.run_status  = status_type'(rsp_bus.run_status);
         tracker.match_response(got);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
          (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(op_type op, addr_word addr, byte_type pb, byte_type ib);
      int unsigned gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.prog_addr <= addr;
      req_bus.prog_byte <= pb;
      req_bus.in_byte   <= ib;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      tracker.take_request(op, addr, pb, ib);
      words_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.due_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_length(logic [LEN_W-1:0] value);
      drain();
      csr_bus.valid          <= 1'b1;
      csr_bus.program_length <= value;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      tracker.prog_len = 32'(value);
      length_writes++;
      csr_bus.valid <= 1'b0;
   endtask

   // Stray loads touch the store from low_addr up to its top.
   task automatic stray_load(int unsigned low_addr);
      send_word(OP_LOAD, addr_word'($urandom_range(low_addr, PROG_DEPTH_DEF - 1)),
                byte_type'($urandom), byte_type'($urandom));
   endtask

   task automatic load_chunk(input byte_type bytes_in [$]);
      foreach (bytes_in[i]) begin
         if ($urandom_range(0, 9) == 0) stray_load(prog_top + bytes_in.size());
         send_word(OP_LOAD, addr_word'(prog_top + i), bytes_in[i], byte_type'($urandom));
      end
      prog_top += bytes_in.size();
   endtask

   // A comma before an open bracket sets a loop count, so it is kept small.
   function automatic byte_type pick_in_byte();
      int unsigned pos;
      pos = tracker.pc;
      if (pos + 1 < PROG_DEPTH_DEF && tracker.program_mem[pos] == CH_IN) begin
         if (tracker.program_mem[pos + 1] == CH_OPEN) begin
            return open_to_zero ? 8'd0 : byte_type'($urandom_range(0, 4));
         end
         if (tracker.program_mem[pos + 1] == CH_CLOSE) begin
            return byte_type'($urandom_range(1, 255));
         end
      end
      return byte_type'($urandom_range(0, 255));
   endfunction

   task automatic step_to_tail();
      while (tracker.halt == ST_RUN && tracker.pc + 1 < tracker.prog_len) begin
         if ($urandom_range(0, 9) == 0) stray_load(prog_top);
         send_word(OP_STEP, addr_word'($urandom), byte_type'($urandom), pick_in_byte());
      end
   endtask

   function automatic byte_type junk_byte();
      byte_type b;
      forever begin
         b = byte_type'($urandom_range(0, 255));
         case (b)
            CH_OPEN, CH_CLOSE, CH_RIGHT, CH_LEFT, CH_INC, CH_DEC, CH_OUT, CH_IN: ;
            default: return b;
         endcase
      end
   endfunction

   function automatic void add_plain(ref byte_type q [$], input int unsigned n, input bit moves);
      repeat (n) begin
         case ($urandom_range(0, moves ? 6 : 4))
            0: q.push_back(CH_INC);
            1: q.push_back(CH_DEC);
            2: q.push_back(CH_OUT);
            3: q.push_back(CH_IN);
            4: q.push_back(junk_byte());
            5: q.push_back(CH_RIGHT);
            default: q.push_back(CH_LEFT);
         endcase
      end
   endfunction

   // The loop counter cell is read from the input and decremented once per
   // pass; the body works on the cells to its right and always returns.
   function automatic void add_loop(ref byte_type q [$]);
      q.push_back(CH_IN);
      q.push_back(CH_OPEN);
      q.push_back(CH_DEC);
      q.push_back(CH_RIGHT);
      add_plain(q, $urandom_range(0, 4), 1'b0);
      case ($urandom_range(0, 2))
         1: begin
            q.push_back(CH_IN);
            q.push_back(CH_OPEN);
            q.push_back(CH_DEC);
            q.push_back(CH_CLOSE);
         end
         2: begin
            q.push_back(CH_IN);
            q.push_back(CH_OPEN);
            q.push_back(CH_DEC);
            q.push_back(CH_RIGHT);
            q.push_back(CH_INC);
            q.push_back(CH_LEFT);
            q.push_back(CH_CLOSE);
         end
         default: ;
      endcase
      add_plain(q, $urandom_range(0, 3), 1'b0);
      q.push_back(CH_LEFT);
      q.push_back(CH_CLOSE);
   endfunction

   initial begin
      byte_type    chunk [$];
      int unsigned ending;
      tracker                = new();
      reset                  <= 1'b1;
      req_bus.valid          <= 1'b0;
      req_bus.operation      <= OP_LOAD;
      req_bus.prog_addr      <= '0;
      req_bus.prog_byte      <= '0;
      req_bus.in_byte        <= '0;
      csr_bus.valid          <= 1'b0;
      csr_bus.program_length <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // A close bracket first on a zero cell, a forward jump over a nested
      // pair, wrapping of cell and pointer, and end of input on the comma.
      write_length('0);
      chunk = '{CH_CLOSE, CH_OPEN, CH_INC, CH_OPEN, CH_CLOSE, CH_CLOSE, CH_DEC, CH_OUT,
                CH_IN, CH_LEFT, CH_OUT, CH_RIGHT, 8'hFF, 8'h00};
      load_chunk(chunk);
      write_length(LEN_W'(prog_top));
      while (tracker.pc + 1 < tracker.prog_len) send_word(OP_STEP, '0, '0, 8'hFF);

      while (words_sent < ITEMS && prog_top + 64 < PROG_DEPTH_DEF) begin
         if (words_sent + CALM_ITEMS >= ITEMS) calm = 1'b1;
         chunk.delete();
         if ($urandom_range(0, 2) == 0) add_plain(chunk, $urandom_range(1, 10), 1'b1);
         else add_loop(chunk);
         chunk.push_back(junk_byte());
         load_chunk(chunk);
         write_length(LEN_W'(prog_top));
         step_to_tail();
      end
      calm = 1'b1;

      // Finish on the program end, a forward scan with no match or a
      // backward scan with no match.
      ending = $urandom_range(0, 2);
      chunk.delete();
      if (ending == 1) begin
         open_to_zero = 1'b1;
         chunk.push_back(CH_IN);
         chunk.push_back(CH_OPEN);
         add_plain(chunk, 3, 1'b1);
      end else if (ending == 2) begin
         chunk.push_back(CH_IN);
         chunk.push_back(CH_CLOSE);
      end
      if (chunk.size() != 0) begin
         chunk.push_back(junk_byte());
         load_chunk(chunk);
         write_length(LEN_W'(prog_top));
      end
      while (tracker.halt == ST_RUN) begin
         send_word(OP_STEP, addr_word'($urandom), byte_type'($urandom), pick_in_byte());
      end

      // Once halted the machine stays halted, whatever the length.
      repeat (3) send_word(OP_STEP, addr_word'($urandom), byte_type'($urandom),
                           byte_type'($urandom));
      stray_load(0);
      write_length('1);
      send_word(OP_STEP, '1, '1, '1);
      write_length(LEN_W'(PROG_DEPTH_DEF));
      send_word(OP_STEP, '0, '0, '0);
      write_length(LEN_W'(PROG_DEPTH_DEF + 1));
      send_word(OP_STEP, addr_word'($urandom), byte_type'($urandom), byte_type'($urandom));

      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d words: %0d loads, %0d steps, %0d bracket jumps, %0d bytes out, %0d in.",
               words_sent, tracker.n_loads, tracker.n_steps, tracker.n_jumps,
               tracker.n_out, tracker.n_in);
      $display("Program of %0d bytes, %0d length writes, halted with %s, %0d errors.",
               prog_top, length_writes, tracker.halt.name(), tracker.n_errors);
      if (tracker.n_errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule : brainfuck_machine_step_tb

FILE: brainfuck_machine_step.f
hdl/bfm_pkg.sv
hdl/bfm_if.sv
hdl/bfm_ram.sv
hdl/bfm_ctrl.sv
hdl/brainfuck_machine_step.sv
verif/brainfuck_machine_step_tb.sv
